### design/integer_to_ascii_formatter_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the integer to ASCII formatter
// Checks are compiled for simulation and left out when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_FORMATTER_ASSERT_SVH
`define INTEGER_TO_ASCII_FORMATTER_ASSERT_SVH
`ifndef SYNTHESIS
// property must hold at every rising clock edge out of reset
`define I2A_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// expression must never be true out of reset
`define I2A_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define I2A_ASSERT(lbl, prop, msg)
`define I2A_NEVER(lbl, expr, msg)
`endif
`endif

### design/i2a_pkg.sv
// ----------------------------------------------------------------------------
// i2a_pkg
// Constants, character codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package i2a_pkg;

    // field limits
    localparam int MAX_WIDTH    = 40;
    localparam int RESULT_LIMIT = 50;
    localparam int NUM_DIGITS   = 22;   // octal digits of a 64-bit word
    localparam int DEC_DIGITS   = 20;   // decimal digits of a 64-bit word
    localparam int DD_BITS      = 4;    // binary bits taken per conversion step
    localparam int DD_STEPS     = 64 / DD_BITS;
    localparam int TOP_POS      = ((MAX_WIDTH > NUM_DIGITS) ? MAX_WIDTH : NUM_DIGITS) - 1;

    // derived widths
    localparam int POS_W  = $clog2(TOP_POS + 2);
    localparam int IDX_W  = $clog2(NUM_DIGITS);
    localparam int CNT_W  = $clog2(RESULT_LIMIT + 1);
    localparam int STEP_W = $clog2(DD_STEPS);

    // base select codes; any other code is hexadecimal
    localparam logic [1:0] BASE_DEC = 2'd0;
    localparam logic [1:0] BASE_OCT = 2'd1;

    // ASCII codes
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_MINUS   = 8'h2D;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic conv;
        logic emit_sign;
        logic emit_digit;
        logic emit_colon;
        logic skip;
    } i2a_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic in_dec;
        logic conv_done;
        logic neg;
        logic print_now;
        logic colon_after;
        logic pos_zero;
        logic at_limit;
        logic out_free;
    } i2a_status_t;

endpackage

### design/integer_to_ascii_formatter.sv
// Sequence: after accept, a decimal item first runs 16 conversion steps; then comes
// the sign step, then the scan skips leading positions that are not printed.
// Per item the scan covers 40 digit positions plus separators.
// Each digit position and each separator is one step of the character scan.
// Output stalls hold the scan; the next item is taken while the last character waits.
// Reset: asynchronous, active low; clears the sequencer and the output valid flag.
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter
// Formats one integer into ASCII characters, most significant first.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter
    import i2a_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] value,
    input  logic        is_unsigned,
    input  logic        wide,
    input  logic [1:0]  base_sel,
    input  logic        upper_case,
    input  logic [5:0]  pad_width,
    input  logic        zero_fill,
    input  logic        group_colons,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  char_out,
    output logic        last
);

    i2a_cmd_t    cmd;
    i2a_status_t st;

    // sequencer
    i2a_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    // datapath
    i2a_dp u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .value        (value),
        .is_unsigned  (is_unsigned),
        .wide         (wide),
        .base_sel     (base_sel),
        .upper_case   (upper_case),
        .pad_width    (pad_width),
        .zero_fill    (zero_fill),
        .group_colons (group_colons),
        .cmd          (cmd),
        .st           (st),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .char_out     (char_out),
        .last         (last)
    );

endmodule

### design/i2a_ctrl.sv
// ----------------------------------------------------------------------------
// i2a_ctrl
// Sequencer: load, decimal conversion, sign, digit scan and separators.
// ----------------------------------------------------------------------------
`include "integer_to_ascii_formatter_assert.svh"

module i2a_ctrl
    import i2a_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  i2a_status_t st,
    output i2a_cmd_t    cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CONV  = 5'b00010,
        S_SIGN  = 5'b00100,
        S_SCAN  = 5'b01000,
        S_COLON = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = st.in_dec ? S_CONV : S_SIGN;
                end
            end
            S_CONV:
            begin
                cmd.conv = 1'b1;
                if (st.conv_done)
                    state_next = S_SIGN;
            end
            S_SIGN:
            begin
                if (!st.neg)
                    state_next = S_SCAN;
                else if (st.out_free)
                begin
                    cmd.emit_sign = 1'b1;
                    state_next    = st.at_limit ? S_IDLE : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (!st.print_now)
                    cmd.skip = 1'b1;
                else if (st.out_free)
                begin
                    cmd.emit_digit = 1'b1;
                    if (st.pos_zero || st.at_limit)
                        state_next = S_IDLE;
                    else if (st.colon_after)
                        state_next = S_COLON;
                end
            end
            S_COLON:
            begin
                if (st.out_free)
                begin
                    cmd.emit_colon = 1'b1;
                    state_next     = st.at_limit ? S_IDLE : S_SCAN;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    `I2A_NEVER(a_emit_needs_room, (cmd.emit_sign || cmd.emit_digit || cmd.emit_colon) && !st.out_free, "character issued while output register busy")
    `I2A_ASSERT(a_colon_resumes_scan, (cmd.emit_colon && !st.at_limit) |=> (state_reg == S_SCAN), "scan not resumed after separator")
    `I2A_ASSERT(a_conv_then_sign, (state_reg == S_CONV && st.conv_done) |=> (state_reg == S_SIGN), "conversion did not end in sign step")

endmodule

### design/i2a_dp.sv
// ----------------------------------------------------------------------------
// i2a_dp
// Operand capture, digit store, binary to BCD conversion and output register.
// ----------------------------------------------------------------------------
`include "integer_to_ascii_formatter_assert.svh"

module i2a_dp
    import i2a_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [63:0] value,
    input  logic        is_unsigned,
    input  logic        wide,
    input  logic [1:0]  base_sel,
    input  logic        upper_case,
    input  logic [5:0]  pad_width,
    input  logic        zero_fill,
    input  logic        group_colons,
    input  i2a_cmd_t    cmd,
    output i2a_status_t st,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  char_out,
    output logic        last
);

    localparam int HEX_PAD = NUM_DIGITS * 4 - 64;
    localparam int OCT_PAD = NUM_DIGITS * 3 - 64;

    // payload registers
    logic [63:0]                 mag_reg,   mag_next;
    logic [NUM_DIGITS-1:0][3:0]  dig_reg,   dig_next;
    logic                        neg_reg;
    logic                        upper_reg;
    logic                        zfill_reg;
    logic                        grp_reg;
    logic [POS_W-1:0]            width_reg;
    logic [7:0]                  char_reg;
    logic                        last_reg;
    // control registers
    logic [STEP_W-1:0]           step_reg,  step_next;
    logic [POS_W-1:0]            pos_reg,   pos_next;
    logic                        seen_reg,  seen_next;
    logic [CNT_W-1:0]            cnt_reg,   cnt_next;
    logic                        valid_reg, valid_next;

    // operand interpretation
    logic [63:0]                 raw;
    logic [63:0]                 neg_full;
    logic                        neg_in;
    logic [63:0]                 mag_in;
    logic [POS_W-1:0]            width_in;
    logic [NUM_DIGITS*4-1:0]     hex_src;
    logic [NUM_DIGITS*3-1:0]     oct_src;
    logic [NUM_DIGITS-1:0][3:0]  load_dig;

    // scan view
    logic [3:0]                  cur_dig;
    logic                        nz;
    logic                        visible;
    logic [7:0]                  digit_ch;
    logic                        emit_any;

    // conversion step
    logic [DEC_DIGITS*4-1:0]     bcd_v;
    logic [63:0]                 bin_v;

    // magnitude and sign of the incoming operand
    always_comb
    begin
        raw      = wide ? value : {32'd0, value[31:0]};
        neg_full = 64'd0 - raw;
        neg_in   = !is_unsigned && (wide ? value[63] : value[31]);
        if (!neg_in)
            mag_in = raw;
        else if (wide)
            mag_in = neg_full;
        else
            mag_in = {32'd0, neg_full[31:0]};
        width_in = (pad_width > 6'(MAX_WIDTH)) ? POS_W'(MAX_WIDTH) : POS_W'(pad_width);
    end

    // digits for power-of-two bases come straight from the bits
    always_comb
    begin
        hex_src = {{HEX_PAD{1'b0}}, mag_in};
        oct_src = {{OCT_PAD{1'b0}}, mag_in};
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (base_sel == BASE_DEC)
                load_dig[i] = 4'd0;
            else if (base_sel == BASE_OCT)
                load_dig[i] = {1'b0, oct_src[3*i +: 3]};
            else
                load_dig[i] = hex_src[4*i +: 4];
        end
    end

    // shift-and-add-3, DD_BITS bits per step
    always_comb
    begin
        bcd_v = dig_reg[DEC_DIGITS-1:0];
        bin_v = mag_reg;
        for (int k = 0; k < DD_BITS; k++)
        begin
            for (int j = 0; j < DEC_DIGITS; j++)
            begin
                if (bcd_v[4*j +: 4] >= 4'd5)
                    bcd_v[4*j +: 4] = bcd_v[4*j +: 4] + 4'd3;
            end
            bcd_v = {bcd_v[DEC_DIGITS*4-2:0], bin_v[63]};
            bin_v = {bin_v[62:0], 1'b0};
        end
    end

    // current position and its character
    always_comb
    begin
        if (pos_reg < POS_W'(NUM_DIGITS))
            cur_dig = dig_reg[pos_reg[IDX_W-1:0]];
        else
            cur_dig = 4'd0;
        nz      = (cur_dig != 4'd0);
        visible = seen_reg || nz || (pos_reg == '0);
        if (!visible)
            digit_ch = zfill_reg ? CH_ZERO : CH_SPACE;
        else if (cur_dig < 4'd10)
            digit_ch = CH_ZERO + {4'd0, cur_dig};
        else
            digit_ch = (upper_reg ? CH_UPPER_A : CH_LOWER_A) + {4'd0, cur_dig} - 8'd10;
    end

    // status to the controller
    always_comb
    begin
        st.in_dec      = (base_sel == BASE_DEC);
        st.conv_done   = (step_reg == STEP_W'(DD_STEPS - 1));
        st.neg         = neg_reg;
        st.print_now   = (pos_reg < width_reg) || visible;
        st.colon_after = grp_reg && (pos_reg[1:0] == 2'b00) && (pos_reg != '0);
        st.pos_zero    = (pos_reg == '0);
        st.at_limit    = (cnt_reg == CNT_W'(RESULT_LIMIT - 1));
        st.out_free    = !valid_reg || !out_stall;
    end

    assign emit_any = cmd.emit_sign || cmd.emit_digit || cmd.emit_colon;

    // next values of the working registers
    always_comb
    begin
        mag_next   = mag_reg;
        dig_next   = dig_reg;
        step_next  = step_reg;
        pos_next   = pos_reg;
        seen_next  = seen_reg;
        cnt_next   = cnt_reg;
        valid_next = valid_reg;
        if (cmd.load)
        begin
            mag_next  = mag_in;
            dig_next  = load_dig;
            step_next = '0;
            pos_next  = POS_W'(TOP_POS);
            seen_next = 1'b0;
            cnt_next  = '0;
        end
        if (cmd.conv)
        begin
            dig_next[DEC_DIGITS-1:0] = bcd_v;
            mag_next  = bin_v;
            step_next = step_reg + 1'b1;
        end
        if (cmd.skip || cmd.emit_colon || (cmd.emit_digit && !st.colon_after))
            pos_next = pos_reg - 1'b1;
        if (cmd.emit_digit && nz)
            seen_next = 1'b1;
        if (emit_any)
        begin
            cnt_next   = cnt_reg + 1'b1;
            valid_next = 1'b1;
        end
        else if (!out_stall)
            valid_next = 1'b0;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= '0;
            pos_reg   <= '0;
            seen_reg  <= 1'b0;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            step_reg  <= step_next;
            pos_reg   <= pos_next;
            seen_reg  <= seen_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        dig_reg <= dig_next;
        if (cmd.load)
        begin
            neg_reg   <= neg_in;
            upper_reg <= upper_case;
            zfill_reg <= zero_fill;
            grp_reg   <= group_colons;
            width_reg <= width_in;
        end
        if (emit_any)
        begin
            if (cmd.emit_sign)
                char_reg <= CH_MINUS;
            else if (cmd.emit_colon)
                char_reg <= CH_COLON;
            else
                char_reg <= digit_ch;
            last_reg <= st.at_limit || (cmd.emit_digit && st.pos_zero);
        end
    end

    assign out_valid = valid_reg;
    assign char_out  = char_reg;
    assign last      = last_reg;

    `I2A_ASSERT(a_conv_drains, (cmd.conv && st.conv_done) |=> (mag_reg == '0), "binary operand not consumed by conversion")
    `I2A_ASSERT(a_units_last, (cmd.emit_digit && st.pos_zero) |=> (valid_reg && last_reg), "units digit not marked last")
    `I2A_ASSERT(a_colon_on_group, cmd.emit_colon |-> (grp_reg && pos_reg[1:0] == 2'b00 && pos_reg != '0), "separator outside a group boundary")

endmodule

### dv/integer_to_ascii_formatter_test.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_test
// Sends integers with mixed format settings through the formatter and checks
// every character and its last flag against a software formatter kept here.
// Directed corner cases come first, then random numbers under several
// sender/receiver idle profiles, with one phase that drains between items.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_test;
    import i2a_pkg::*;

    localparam logic [1:0] BASE_HEX      = 2'd2;
    localparam logic [1:0] BASE_HEX_ALT  = 2'd3;   // unused code, behaves as hex
    localparam int         DIGIT_SLOTS   = 72;
    localparam int         TAIL_CYCLES   = 70;
    localparam int         WATCHDOG_MAX  = 4000;

    // one number with its format settings
    typedef struct {
        logic [63:0] value;
        logic        is_unsigned;
        logic        wide;
        logic [1:0]  base_sel;
        logic        upper_case;
        logic [5:0]  pad_width;
        logic        zero_fill;
        logic        group_colons;
    } fmt_req_t;

    // one expected character
    typedef struct {
        logic [7:0] ch;
        logic       last;
    } char_exp_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [63:0] value;
    logic        is_unsigned;
    logic        wide;
    logic [1:0]  base_sel;
    logic        upper_case;
    logic [5:0]  pad_width;
    logic        zero_fill;
    logic        group_colons;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  char_out;
    logic        last;

    char_exp_t   pending_chars[$];
    int          mismatch_count = 0;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    int          quiet_cycles = 0;

    integer_to_ascii_formatter dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .value        (value),
        .is_unsigned  (is_unsigned),
        .wide         (wide),
        .base_sel     (base_sel),
        .upper_case   (upper_case),
        .pad_width    (pad_width),
        .zero_fill    (zero_fill),
        .group_colons (group_colons),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .char_out     (char_out),
        .last         (last)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // works out the characters for one number and queues them
    function automatic void predict_chars(input fmt_req_t req);
        logic [63:0] mag;
        logic        negative;
        logic [4:0]  radix;
        logic [3:0]  digit;
        int          field_w;
        int          n;
        int          i;
        logic [7:0]  slots[DIGIT_SLOTS];
        logic [7:0]  text[$];
        char_exp_t   exp_ch;

        mag      = req.wide ? req.value : {32'd0, req.value[31:0]};
        negative = 1'b0;
        if (!req.is_unsigned)
        begin
            if (req.wide && mag[63])
            begin
                negative = 1'b1;
                mag      = -mag;
            end
            else if (!req.wide && mag[31])
            begin
                negative = 1'b1;
                mag      = 64'h1_0000_0000 - mag;
            end
        end

        radix   = (req.base_sel == BASE_DEC) ? 5'd10 :
                  (req.base_sel == BASE_OCT) ? 5'd8 : 5'd16;
        field_w = (req.pad_width > MAX_WIDTH) ? MAX_WIDTH : int'(req.pad_width);

        // positions least significant first; fill once the value runs out
        n = 0;
        while ((n == 0 || mag != 0 || n < field_w) && n < DIGIT_SLOTS)
        begin
            digit = 4'(mag % radix);
            if (mag == 0 && n != 0)
                slots[n] = req.zero_fill ? CH_ZERO : CH_SPACE;
            else if (digit < 10)
                slots[n] = CH_ZERO + digit;
            else
                slots[n] = (req.upper_case ? CH_UPPER_A : CH_LOWER_A) + digit - 8'd10;
            n++;
            mag = mag / radix;
        end

        // sign, then positions most significant first with separators
        if (negative)
            text.push_back(CH_MINUS);
        while (n > 0)
        begin
            n--;
            text.push_back(slots[n]);
            if (req.group_colons && n > 0 && (n % 4) == 0)
                text.push_back(CH_COLON);
        end

        // anything past the result limit is dropped
        if (text.size() > RESULT_LIMIT)
            text = text[0:RESULT_LIMIT-1];
        for (i = 0; i < text.size(); i++)
        begin
            exp_ch.ch   = text[i];
            exp_ch.last = (i == text.size() - 1);
            pending_chars.push_back(exp_ch);
        end
    endfunction

    function automatic fmt_req_t make_req(input logic [63:0] v, input logic uns,
                                          input logic wd, input logic [1:0] bsel,
                                          input logic upper, input logic [5:0] pw,
                                          input logic zf, input logic grp);
        fmt_req_t req;
        req.value        = v;
        req.is_unsigned  = uns;
        req.wide         = wd;
        req.base_sel     = bsel;
        req.upper_case   = upper;
        req.pad_width    = pw;
        req.zero_fill    = zf;
        req.group_colons = grp;
        return req;
    endfunction

    // random number, biased towards zero, small values and sign boundaries
    function automatic fmt_req_t random_req();
        fmt_req_t    req;
        logic [63:0] v;
        logic [31:0] offs;

        offs = $urandom_range(0, 300);
        case ($urandom_range(0, 7))
            0:       v = {$urandom, 32'd0};
            1:       v = {$urandom, 32'd0} | $urandom_range(0, 9999);
            2:       v = {$urandom, 32'h8000_0000 + offs};
            3:       v = {$urandom, 32'h7FFF_FFFF - offs};
            4:       v = 64'h8000_0000_0000_0000 + offs;
            5:       v = 64'h7FFF_FFFF_FFFF_FFFF - offs;
            6:       v = -{32'd0, $urandom_range(1, 99999)};
            default: v = {$urandom, $urandom};
        endcase
        if (v[31:0] == 32'd0 && $urandom_range(0, 1))
            v = 64'd0;
        req = make_req(v, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                       ($urandom_range(0, 9) == 0) ? 6'($urandom_range(41, 63))
                                                   : 6'($urandom_range(0, 40)),
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        return req;
    endfunction

    // drives one number and holds it until the block takes it
    task automatic send_number(input fmt_req_t req);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        value        <= req.value;
        is_unsigned  <= req.is_unsigned;
        wide         <= req.wide;
        base_sel     <= req.base_sel;
        upper_case   <= req.upper_case;
        pad_width    <= req.pad_width;
        zero_fill    <= req.zero_fill;
        group_colons <= req.group_colons;
        predict_chars(req);
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic wait_for_drain();
        in_valid <= 1'b0;
        while (pending_chars.size() != 0)
            @(posedge clk);
    endtask

    // corner cases of value, base, width, fill and grouping
    task automatic test_directed_cases();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_number(make_req(64'd0, 1'b0, 1'b0, BASE_DEC, 1'b0, 6'd0, 1'b0, 1'b0));
        send_number(make_req(64'd0, 1'b0, 1'b0, BASE_DEC, 1'b0, 6'd5, 1'b0, 1'b0));
        send_number(make_req(64'd0, 1'b1, 1'b1, BASE_HEX, 1'b0, 6'd5, 1'b1, 1'b1));
        send_number(make_req('1, 1'b0, 1'b0, BASE_DEC, 1'b0, 6'd0, 1'b0, 1'b0));
        send_number(make_req('1, 1'b1, 1'b0, BASE_DEC, 1'b0, 6'd0, 1'b0, 1'b1));
        // most negative operands print their full magnitude
        send_number(make_req(64'h0000_0000_8000_0000, 1'b0, 1'b0, BASE_DEC,
                             1'b0, 6'd0, 1'b0, 1'b0));
        send_number(make_req(64'h8000_0000_0000_0000, 1'b0, 1'b1, BASE_DEC,
                             1'b0, 6'd0, 1'b0, 1'b1));
        send_number(make_req(64'h8000_0000_0000_0000, 1'b0, 1'b1, BASE_OCT,
                             1'b0, 6'd0, 1'b0, 1'b0));
        send_number(make_req(64'hFFFF_FFFF_7FFF_FFFF, 1'b0, 1'b0, BASE_HEX,
                             1'b1, 6'd0, 1'b0, 1'b0));
        send_number(make_req('1, 1'b1, 1'b1, BASE_DEC, 1'b0, 6'd0, 1'b0, 1'b1));
        send_number(make_req('1, 1'b1, 1'b1, BASE_OCT, 1'b0, 6'd0, 1'b0, 1'b0));
        send_number(make_req('1, 1'b1, 1'b1, BASE_HEX, 1'b0, 6'd0, 1'b0, 1'b1));
        send_number(make_req(64'hDEAD_BEEF_CAFE_F00D, 1'b1, 1'b1, BASE_HEX_ALT,
                             1'b1, 6'd0, 1'b0, 1'b0));
        send_number(make_req(64'hDEAD_BEEF_CAFE_F00D, 1'b1, 1'b1, BASE_HEX_ALT,
                             1'b0, 6'd0, 1'b0, 1'b0));
        // sign comes before space fill and before zero fill
        send_number(make_req(-64'd42, 1'b0, 1'b1, BASE_DEC, 1'b0, 6'd8, 1'b0, 1'b0));
        send_number(make_req(-64'd42, 1'b0, 1'b0, BASE_DEC, 1'b0, 6'd8, 1'b1, 1'b1));
        // longest output: sign, forty positions and nine separators
        send_number(make_req(-64'd1, 1'b0, 1'b1, BASE_HEX, 1'b1, 6'd40, 1'b1, 1'b1));
        // widths above the limit saturate, and a width below the digit count adds no fill
        send_number(make_req(64'd12345, 1'b1, 1'b0, BASE_DEC, 1'b0, 6'd41, 1'b1, 1'b1));
        send_number(make_req(64'hABC, 1'b1, 1'b0, BASE_HEX, 1'b0, 6'd63, 1'b0, 1'b1));
        send_number(make_req(64'd8, 1'b1, 1'b0, BASE_OCT, 1'b0, 6'd1, 1'b0, 1'b0));
        // upper operand bits ignored for narrow values
        send_number(make_req(64'hA5A5_A5A5_0000_0123, 1'b1, 1'b0, BASE_HEX,
                             1'b0, 6'd4, 1'b1, 1'b0));
    endtask

    // sender holds off until every pending character is back
    task automatic test_drain_between_items(input int count);
        int i;
        tx_idle_pct = 10;
        rx_idle_pct = 40;
        for (i = 0; i < count; i++)
        begin
            send_number(random_req());
            wait_for_drain();
        end
    endtask

    task automatic test_random_numbers(input int count, input int tx_pct,
                                       input int rx_pct);
        int i;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (i = 0; i < count; i++)
            send_number(random_req());
    endtask

    // receiver stall
    always @(posedge clk)
        out_stall <= ($urandom_range(0, 99) < rx_idle_pct);

    // result checker
    always @(posedge clk)
    begin
        char_exp_t exp_ch;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_chars.size() == 0)
            begin
                $error("char_out: unexpected item 0x%02h (last %0b)", char_out, last);
                mismatch_count++;
            end
            else
            begin
                exp_ch = pending_chars.pop_front();
                if (char_out !== exp_ch.ch)
                begin
                    $error("char_out: expected 0x%02h, got 0x%02h", exp_ch.ch, char_out);
                    mismatch_count++;
                end
                if (last !== exp_ch.last)
                begin
                    $error("last: expected %0b, got %0b", exp_ch.last, last);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_MAX)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // test sequence
    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        value        = '0;
        is_unsigned  = 1'b0;
        wide         = 1'b0;
        base_sel     = BASE_DEC;
        upper_case   = 1'b0;
        pad_width    = '0;
        zero_fill    = 1'b0;
        group_colons = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_drain_between_items(8);
        test_random_numbers(70, 26, 67);
        test_random_numbers(70, 67, 26);
        test_random_numbers(70, 0, 0);

        // let the last characters out, then watch for strays
        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_chars.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
